// ===== sv/assert_macros.svh =====
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at each rising edge, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at each rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/utf8d_pkg.sv =====
// Types and constants shared by the UTF-8 decoder modules.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    localparam int unsigned UTF8D_QUEUE_DEPTH = 4;
    localparam int unsigned CP_W = 21;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_END     = 2'd2
    } t_status;

    // One command per input byte that yields results: a burst of invalid
    // marks followed by an optional final result.
    typedef struct packed {
        logic [1:0]      n_inv;
        logic            has_tail;
        t_status         tail_status;
        logic [CP_W-1:0] tail_cp;
    } t_cmd;

    // Queue state as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

`default_nettype wire

// ===== sv/utf8d_front.sv =====
// Front end: accepts bytes, tracks the open sequence and classifies each byte.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [7:0]      i_s_tdata,
    input  wire logic            i_full,
    output logic                 o_push,
    output utf8d_pkg::t_cmd      o_cmd
);
    import utf8d_pkg::*;

    logic [1:0]      r_need;
    logic [1:0]      r_held;
    logic [CP_W-1:0] r_pp;
    logic [1:0]      n_need;
    logic [1:0]      n_held;
    logic [CP_W-1:0] n_pp;

    logic            w_accept;
    logic [7:0]      w_b;
    logic            w_id_tail;
    t_status         w_id_st;
    logic [CP_W-1:0] w_id_cp;
    logic [1:0]      w_id_need;
    logic [CP_W-1:0] w_id_pp;
    logic [CP_W-1:0] w_gath;
    t_cmd            w_cmd;

    assign w_b        = i_s_tdata;
    assign o_s_tready = !i_full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // How a byte acts when no sequence is open.
    always_comb begin
        w_id_tail = 1'b0;
        w_id_st   = ST_VALID;
        w_id_cp   = '0;
        w_id_need = 2'd0;
        w_id_pp   = '0;
        if (w_b == 8'h00) begin
            w_id_tail = 1'b1;
            w_id_st   = ST_END;
        end else if (!w_b[7]) begin
            w_id_tail = 1'b1;
            w_id_cp   = {{(CP_W-8){1'b0}}, w_b};
        end else if (w_b[7:5] == 3'b110) begin
            w_id_need = 2'd1;
            w_id_pp   = {{(CP_W-5){1'b0}}, w_b[4:0]};
        end else if (w_b[7:4] == 4'b1110) begin
            w_id_need = 2'd2;
            w_id_pp   = {{(CP_W-4){1'b0}}, w_b[3:0]};
        end else if (w_b[7:3] == 5'b11110) begin
            w_id_need = 2'd3;
            w_id_pp   = {{(CP_W-3){1'b0}}, w_b[2:0]};
        end else begin
            w_id_tail = 1'b1;
            w_id_st   = ST_INVALID;
        end
    end

    assign w_gath = {r_pp[CP_W-7:0], w_b[5:0]};

    always_comb begin
        w_cmd.n_inv       = 2'd0;
        w_cmd.has_tail    = w_id_tail;
        w_cmd.tail_status = w_id_st;
        w_cmd.tail_cp     = w_id_cp;
        n_need            = w_id_need;
        n_held            = 2'd0;
        n_pp              = w_id_pp;
        if (r_need != 2'd0) begin
            if (w_b[7:6] == 2'b10) begin
                if (r_need == 2'd1) begin
                    w_cmd.has_tail    = 1'b1;
                    w_cmd.tail_status = ST_VALID;
                    w_cmd.tail_cp     = w_gath;
                    n_need            = 2'd0;
                    n_held            = 2'd0;
                    n_pp              = '0;
                end else begin
                    w_cmd.has_tail = 1'b0;
                    n_need         = r_need - 2'd1;
                    n_held         = r_held + 2'd1;
                    n_pp           = w_gath;
                end
            end else begin
                // Broken sequence: the lead and each held continuation are
                // reported invalid, then the byte is taken as a fresh lead.
                w_cmd.n_inv = 2'd1 + ((r_held > 2'd2) ? 2'd2 : r_held);
            end
        end
    end

    assign o_cmd  = w_cmd;
    assign o_push = w_accept && ((w_cmd.n_inv != 2'd0) || w_cmd.has_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need <= 2'd0;
            r_held <= 2'd0;
            r_pp   <= '0;
        end else if (w_accept) begin
            r_need <= n_need;
            r_held <= n_held;
            r_pp   <= n_pp;
        end
    end

endmodule

`default_nettype wire

// ===== sv/utf8d_queue.sv =====
// Command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8d_queue #(
    parameter int unsigned DEPTH = utf8d_pkg::UTF8D_QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire utf8d_pkg::t_cmd i_cmd,
    input  wire logic            i_pop,
    output logic                 o_full,
    output utf8d_pkg::t_head     o_head
);
    import utf8d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_pop;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_entry[r_rd_ptr];
    assign w_do_pop     = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_CLK(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, r_count <= FULL_CNT, "queue count out of range")
    `ASSERT_CLK(a_count_up, i_clk, i_rst_n, (i_push && !w_do_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count did not grow")

endmodule

`default_nettype wire

// ===== sv/utf8d_back.sv =====
// Back end: expands queued commands into result items, one per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8d_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire utf8d_pkg::t_head i_head,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [23:0]           o_m_tdata,
    output logic [1:0]            o_m_tuser,
    output logic                  o_m_tlast
);
    import utf8d_pkg::*;

    logic            r_valid;
    logic [1:0]      r_sub;
    logic [CP_W-1:0] r_cp;
    t_status         r_st;
    logic            r_last;

    logic            w_adv;
    logic            w_take;
    logic            w_in_burst;
    t_status         w_st;
    logic [CP_W-1:0] w_cp;
    logic            w_last;

    assign w_adv      = !r_valid || i_m_tready;
    assign w_take     = w_adv && i_head.valid;
    assign w_in_burst = (r_sub < i_head.cmd.n_inv);

    always_comb begin
        if (w_in_burst) begin
            w_st   = ST_INVALID;
            w_cp   = '0;
            w_last = (r_sub == i_head.cmd.n_inv - 2'd1) && !i_head.cmd.has_tail;
        end else begin
            w_st   = i_head.cmd.tail_status;
            w_cp   = i_head.cmd.tail_cp;
            w_last = 1'b1;
        end
    end

    assign o_pop = w_take && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else if (w_adv) begin
            r_valid <= i_head.valid;
            if (w_take) begin
                r_sub <= w_last ? 2'd0 : r_sub + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cp   <= w_cp;
            r_st   <= w_st;
            r_last <= w_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(24-CP_W){1'b0}}, r_cp};
    assign o_m_tuser  = r_st;
    assign o_m_tlast  = r_last;

    `ASSERT_CLK(a_cp_zero, i_clk, i_rst_n, (r_valid && r_st != ST_VALID) |-> (r_cp == '0), "code point set on a mark")
    `ASSERT_CLK(a_sub_bound, i_clk, i_rst_n, i_head.valid |-> (w_in_burst || i_head.cmd.has_tail), "result index past command")
    `ASSERT_CLK(a_sub_idle, i_clk, i_rst_n, !i_head.valid |-> (r_sub == 2'd0), "result index left over")

endmodule

`default_nettype wire

// ===== sv/utf8_byte_stream_decoder_core.sv =====
// Top level of the UTF-8 byte stream decoder.
//
//  port group   dir  contents
//  i_s_*        in   one text byte per item (tdata[7:0])
//  o_m_*        out  code point (tdata[20:0]), status (tuser[1:0]), tlast
//
// A byte enters every cycle unless the command queue is full; the front end
// decides its results in the same cycle and queues them as one command. The
// back end emits one result per cycle while the receiver is ready, so a
// broken sequence that yields up to four results holds the output, absorbed
// by the QUEUE_DEPTH command queue. Results are registered in the queue and
// again at the back end output. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module utf8_byte_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = utf8d_pkg::UTF8D_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]       o_m_tuser,   // [1:0] status
    output logic             o_m_tlast
);
    import utf8d_pkg::*;

    logic  w_push;
    t_cmd  w_cmd;
    logic  w_full;
    logic  w_pop;
    t_head w_head;

    utf8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    utf8d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== test/utf8_byte_stream_decoder_core_checker.sv =====
// Result checker for the UTF-8 decoder: predicts decoded results per byte and compares them.
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_core_checker
    import utf8d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,   // [20:0] code_point, [23:21] zero
    input  wire logic [1:0]  i_m_tuser,   // [1:0] status
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        t_status         status;
        logic            last;
    } t_decoded;

    t_decoded        decoded_fifo[$];
    logic [1:0]      cont_left;
    logic [1:0]      cont_held;
    logic [CP_W-1:0] partial_cp;
    int              fail_total;
    int              checked_total;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_total++;
    endtask

    task automatic push_decoded(input logic [CP_W-1:0] cp, input t_status st);
        t_decoded r;
        r.code_point = cp;
        r.status     = st;
        r.last       = 1'b0;
        decoded_fifo.push_back(r);
    endtask

    // Byte seen with no sequence open: emit at once or open a sequence.
    task automatic decode_idle_byte(input logic [7:0] b);
        if (b == 8'h00) begin
            push_decoded('0, ST_END);
        end else if (!b[7]) begin
            push_decoded(CP_W'(b), ST_VALID);
        end else if (b[7:5] == 3'b110) begin
            partial_cp = CP_W'(b[4:0]);
            cont_left  = 2'd1;
            cont_held  = 2'd0;
        end else if (b[7:4] == 4'b1110) begin
            partial_cp = CP_W'(b[3:0]);
            cont_left  = 2'd2;
            cont_held  = 2'd0;
        end else if (b[7:3] == 5'b11110) begin
            partial_cp = CP_W'(b[2:0]);
            cont_left  = 2'd3;
            cont_held  = 2'd0;
        end else begin
            push_decoded('0, ST_INVALID);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int       first;
        t_decoded tail;
        first = decoded_fifo.size();
        if (cont_left == 2'd0) begin
            decode_idle_byte(b);
        end else if (b[7:6] == 2'b10) begin
            partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
            cont_held  = cont_held + 2'd1;
            cont_left  = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                push_decoded(partial_cp, ST_VALID);
                partial_cp = '0;
                cont_held  = 2'd0;
            end
        end else begin
            // The lead and every continuation already held are dropped as invalid,
            // then the breaking byte starts over as a fresh lead.
            push_decoded('0, ST_INVALID);
            repeat (cont_held) push_decoded('0, ST_INVALID);
            cont_left  = 2'd0;
            cont_held  = 2'd0;
            partial_cp = '0;
            decode_idle_byte(b);
        end
        if (decoded_fifo.size() > first) begin
            tail = decoded_fifo.pop_back();
            tail.last = 1'b1;
            decoded_fifo.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            cont_left  = 2'd0;
            cont_held  = 2'd0;
            partial_cp = '0;
            decoded_fifo.delete();
        end else begin
            // Results leave the DUT only after their byte is registered, so compare before predicting.
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_fifo.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: tdata=%h tuser=%0d tlast=%b",
                                              i_m_tdata, i_m_tuser, i_m_tlast));
                end else begin
                    want = decoded_fifo.pop_front();
                    checked_total++;
                    if (i_m_tdata !== {3'b000, want.code_point})
                        report_mismatch($sformatf("code point %h, expected %h",
                                                  i_m_tdata, want.code_point));
                    if (i_m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  i_m_tuser, want.status.name()));
                    if (i_m_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b, expected %b",
                                                  i_m_tlast, want.last));
                end
            end
            if (i_s_tvalid && i_s_tready) decode_byte(i_s_tdata);
        end
        o_fail_count <= fail_total;
        o_pending    <= decoded_fifo.size();
        o_checked    <= checked_total;
    end

endmodule

// ===== test/utf8_byte_stream_decoder_core_tb.sv =====
// Testbench top for the UTF-8 decoder: drives byte streams, stalls both sides, gives the verdict.
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_core_tb;
    import utf8d_pkg::*;

    localparam int ITEM_TARGET = 323;
    localparam int CALM_TAIL   = 40;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 20;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata    = 8'h00;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          checked;
    int          quiet_cycles = 0;
    bit          calm       = 1'b0;

    utf8_byte_stream_decoder_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    utf8_byte_stream_decoder_core_checker decode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] random_lead(input int seq_len);
        case (seq_len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] random_continuation();
        return {2'b10, 6'($urandom)};
    endfunction

    // Receiver: random stall bursts, none once the run winds down.
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("utf8_byte_stream_decoder_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] text_bytes[$];
        logic [7:0] breaker;
        int         directed_count;
        int         seq_len;
        int         cut;
        int         pick;

        // ASCII and end mark, a two-byte form, longer forms with all payload bits set,
        // stray bytes, a break that yields four invalid marks, a break by ASCII, a zero
        // inside a sequence, and a lead that breaks one sequence while opening the next.
        text_bytes = '{8'h41, 8'h7F, 8'h00,
                       8'hC3, 8'hA9,
                       8'hEF, 8'hBF, 8'hBF,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF,
                       8'h80, 8'hF8,
                       8'hF0, 8'h90, 8'h80, 8'hFF,
                       8'hE2, 8'h82, 8'h41,
                       8'hC3, 8'h00,
                       8'hC3, 8'hE2, 8'h82, 8'hAC};
        directed_count = text_bytes.size();

        // Mostly well-formed sequences with random payload; the rest is noise
        // and sequences cut short by a non-continuation byte.
        while (text_bytes.size() < directed_count + ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                text_bytes.push_back(8'($urandom_range(1, 127)));
            end else if (pick < 35) begin
                text_bytes.push_back(8'h00);
            end else if (pick < 80) begin
                seq_len = $urandom_range(2, 4);
                text_bytes.push_back(random_lead(seq_len));
                repeat (seq_len - 1) text_bytes.push_back(random_continuation());
            end else if (pick < 90) begin
                text_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                seq_len = $urandom_range(2, 4);
                cut     = $urandom_range(0, seq_len - 2);
                breaker = 8'($urandom_range(0, 255));
                if (breaker[7:6] == 2'b10) breaker = breaker ^ 8'h40;
                text_bytes.push_back(random_lead(seq_len));
                repeat (cut) text_bytes.push_back(random_continuation());
                text_bytes.push_back(breaker);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < text_bytes.size(); n++) begin
            calm = (n >= text_bytes.size() - CALM_TAIL);
            if (n == directed_count) begin
                // Hold the sender until the directed results have all drained.
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_bytes[n];
            @(posedge clk);
            while (!s_tready) @(posedge clk);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d bytes: %0d directed, the rest random text, noise and cut sequences.",
                 text_bytes.size(), directed_count);
        $display("Compared %0d decoded results under random stalls on both sides.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("utf8_byte_stream_decoder_core verification clean");
        end else begin
            if (pending != 0) $display("%0d expected results never arrived", pending);
            $display("utf8_byte_stream_decoder_core verification failed");
        end
        $finish;
    end

endmodule
